// ===== sv/arp_cache_lru_defines.svh =====
// assertion macros for the address-resolution cache
`ifndef ARP_CACHE_LRU_DEFINES_SVH
`define ARP_CACHE_LRU_DEFINES_SVH

`ifndef SYNTHESIS
`define ACL_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acl check failed");
`define ACL_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acl check failed");
`else
`define ACL_CHK_IMP(lbl, ante, cons)
`define ACL_CHK_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/acl_pkg.sv =====
// shared types and constants of the address-resolution cache
package acl_pkg;

  localparam int ENTRIES_DEF     = 256;
  localparam int MEDIUM_BITS_DEF = 4;
  localparam logic [3:0] GOOD_MAC_LEN = 4'd6;
  localparam logic [63:0] V4_PREFIX   = 64'h0000_ffff_0000_0000;

  localparam logic [1:0] SL_UNUSED = 2'd0;
  localparam logic [1:0] SL_OK     = 2'd1;
  localparam logic [1:0] SL_WAIT   = 2'd2;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_ENTER   = 2'd1,
    ACT_RESOLVE = 2'd2,
    ACT_FLUSH   = 2'd3
  } acl_action_t;

  typedef enum logic [2:0] {
    STS_HIT     = 3'd0,
    STS_PENDING = 3'd1,
    STS_NEW     = 3'd2,
    STS_UPDATED = 3'd3,
    STS_INSERT  = 3'd4,
    STS_IGNORED = 3'd5,
    STS_DONE    = 3'd6
  } acl_status_t;

  typedef struct packed {
    acl_action_t action;
    logic        is_v4;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [3:0]  medium_req;
    logic [47:0] new_mac;
    logic [3:0]  mac_length;
    logic        refresh;
    logic [7:0]  entry_index;
    logic [31:0] now_ms;
  } acl_in_t;

  typedef struct packed {
    acl_status_t status;
    logic [47:0] mac_out;
    logic [7:0]  slot_out;
    logic        evicted_valid;
  } acl_out_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [47:0] mac;
    logic [31:0] last;
  } acl_entry_t;

endpackage

// ===== sv/acl_store.sv =====
// slot storage: entry memory and medium memory, one write and one read port
module acl_store #(
  parameter int ENTRIES     = acl_pkg::ENTRIES_DEF,
  parameter int MEDIUM_BITS = acl_pkg::MEDIUM_BITS_DEF,
  parameter int AW          = $clog2(ENTRIES)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic                   med_we,
  input  logic [AW-1:0]          waddr,
  input  acl_pkg::acl_entry_t    wdata,
  input  logic [MEDIUM_BITS-1:0] wmed,
  input  logic                   rd_en,
  input  logic [AW-1:0]          raddr,
  output acl_pkg::acl_entry_t    rdata,
  output logic [MEDIUM_BITS-1:0] rmed
);
  import acl_pkg::*;

  acl_entry_t             mem_main [ENTRIES];
  logic [MEDIUM_BITS-1:0] mem_med  [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_main[waddr] <= wdata;
    end
    if (med_we) begin
      mem_med[waddr] <= wmed;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem_main[raddr];
      rmed  <= mem_med[raddr];
    end
  end

endmodule

// ===== sv/arp_cache_lru.sv =====
// address-resolution cache with lru replacement, one slot scanned per cycle
//
//   channel | ports                        | handshake
//   input   | start, busy, in_item         | word taken when start && !busy
//   result  | out_valid, out_item          | one-cycle strobe, cannot stall
//
// get and enter scan every slot through one read port.
// resolve reads then rewrites one slot; bad requests go straight to the result.
// flush sweeps one slot per cycle.
// after reset a clearing pass over every slot runs with busy high.
// one result word per accepted word; the receiver never holds it off.
`include "arp_cache_lru_defines.svh"
module arp_cache_lru #(
  parameter int ENTRIES     = acl_pkg::ENTRIES_DEF,
  parameter int MEDIUM_BITS = acl_pkg::MEDIUM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  acl_pkg::acl_in_t in_item,
  output logic             out_valid,
  output acl_pkg::acl_out_t out_item
);
  import acl_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_RES, S_RESW, S_DONE
  } state_t;

  state_t                 state_r;
  logic [AW-1:0]          addr_r, idx_r, waddr_r;
  logic                   iss_done_r, vld_r, flush_r, wen_r, wmed_r;
  acl_action_t            act_r;
  logic                   refresh_r;
  logic [63:0]            hi_r, lo_r;
  logic [MEDIUM_BITS-1:0] med_r;
  logic [47:0]            mac_r;
  logic [31:0]            now_r;
  acl_entry_t             wword_r;
  acl_out_t               out_r;

  logic                   fnd_r, fnd_nxt;
  logic [AW-1:0]          fidx_r, fidx_nxt, vidx_r, vidx_nxt;
  acl_entry_t             fword_r, fword_nxt, vword_r, vword_nxt;

  acl_entry_t             rdata;
  logic [MEDIUM_BITS-1:0] rmed;
  logic                   rd_en, we, med_we, match, first, idle_take;
  logic [AW-1:0]          waddr;
  acl_entry_t             wdata;
  logic [MEDIUM_BITS-1:0] wmed;
  logic [63:0]            in_hi, in_lo;

  assign rd_en  = (state_r == S_SCAN && !iss_done_r) || state_r == S_RES;
  assign we     = state_r == S_CLEAR || (state_r == S_DONE && wen_r);
  assign med_we = (state_r == S_CLEAR && !flush_r) || (state_r == S_DONE && wen_r && wmed_r);
  assign waddr  = (state_r == S_CLEAR) ? addr_r : waddr_r;
  assign wdata  = (state_r == S_CLEAR) ? '0 : wword_r;
  assign wmed   = (state_r == S_CLEAR) ? '0 : med_r;

  acl_store #(
    .ENTRIES    (ENTRIES),
    .MEDIUM_BITS(MEDIUM_BITS),
    .AW         (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .med_we(med_we),
    .waddr (waddr),
    .wdata (wdata),
    .wmed  (wmed),
    .rd_en (rd_en),
    .raddr (addr_r),
    .rdata (rdata),
    .rmed  (rmed)
  );

  assign in_hi = in_item.is_v4 ? 64'd0 : in_item.ip_high;
  assign in_lo = in_item.is_v4 ? (V4_PREFIX | {32'd0, in_item.ip_low[31:0]}) : in_item.ip_low;
  assign idle_take = state_r == S_IDLE && start;

  // running match and lru search
  always_comb begin
    first = idx_r == '0;
    match = (rdata.st == SL_OK || rdata.st == SL_WAIT) && rdata.ip_high == hi_r &&
            rdata.ip_low == lo_r && rmed == med_r;
    fnd_nxt   = first ? 1'b0 : fnd_r;
    fidx_nxt  = fidx_r;
    fword_nxt = fword_r;
    vidx_nxt  = vidx_r;
    vword_nxt = vword_r;
    if (vld_r) begin
      if (match && !fnd_nxt) begin
        fnd_nxt   = 1'b1;
        fidx_nxt  = idx_r;
        fword_nxt = rdata;
      end
      if (first || rdata.last < vword_r.last) begin
        vidx_nxt  = idx_r;
        vword_nxt = rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      flush_r    <= 1'b0;
      iss_done_r <= 1'b0;
      vld_r      <= 1'b0;
      wen_r      <= 1'b0;
    end else begin
      vld_r <= state_r == S_SCAN && !iss_done_r;
      idx_r <= addr_r;
      fnd_r   <= fnd_nxt;
      fidx_r  <= fidx_nxt;
      fword_r <= fword_nxt;
      vidx_r  <= vidx_nxt;
      vword_r <= vword_nxt;
      case (state_r)
        S_CLEAR: begin
          if (addr_r == LAST_IDX) begin
            addr_r <= '0;
            if (flush_r) begin
              out_r   <= '{status: STS_DONE, mac_out: '0, slot_out: '0, evicted_valid: 1'b0};
              wen_r   <= 1'b0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            addr_r <= addr_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            act_r     <= in_item.action;
            refresh_r <= in_item.refresh;
            hi_r      <= in_hi;
            lo_r      <= in_lo;
            med_r     <= MEDIUM_BITS'(in_item.medium_req);
            mac_r     <= in_item.new_mac;
            now_r     <= in_item.now_ms;
            wen_r     <= 1'b0;
            out_r     <= '{status: STS_IGNORED, mac_out: '0, slot_out: '0,
                           evicted_valid: 1'b0};
            addr_r     <= (in_item.action == ACT_RESOLVE) ? AW'(in_item.entry_index) : '0;
            iss_done_r <= 1'b0;
            case (in_item.action)
              ACT_GET: state_r <= S_SCAN;
              ACT_ENTER: begin
                state_r <= (in_item.mac_length == GOOD_MAC_LEN) ? S_SCAN : S_DONE;
              end
              ACT_RESOLVE: begin
                state_r <= (int'(in_item.entry_index) < ENTRIES) ? S_RES : S_DONE;
              end
              default: begin
                flush_r <= 1'b1;
                state_r <= S_CLEAR;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!iss_done_r) begin
            addr_r <= addr_r + AW'(1);
            if (addr_r == LAST_IDX) begin
              iss_done_r <= 1'b1;
            end
          end
          if (vld_r && idx_r == LAST_IDX) begin
            state_r <= S_DONE;
            if (fnd_nxt) begin
              wen_r   <= 1'b1;
              wmed_r  <= 1'b0;
              waddr_r <= fidx_nxt;
              if (act_r == ACT_GET) begin
                wword_r <= '{st: fword_nxt.st, ip_high: fword_nxt.ip_high,
                             ip_low: fword_nxt.ip_low, mac: fword_nxt.mac, last: now_r};
                out_r   <= '{status: (fword_nxt.st == SL_WAIT) ? STS_PENDING : STS_HIT,
                             mac_out: (fword_nxt.st == SL_WAIT) ? 48'd0 : fword_nxt.mac,
                             slot_out: 8'(fidx_nxt), evicted_valid: 1'b0};
              end else begin
                wword_r <= '{st: SL_OK, ip_high: fword_nxt.ip_high,
                             ip_low: fword_nxt.ip_low, mac: mac_r, last: now_r};
                out_r   <= '{status: STS_UPDATED, mac_out: '0,
                             slot_out: 8'(fidx_nxt), evicted_valid: 1'b0};
              end
            end else if (act_r == ACT_GET || !refresh_r) begin
              wen_r   <= 1'b1;
              wmed_r  <= 1'b1;
              waddr_r <= vidx_nxt;
              wword_r <= '{st: (act_r == ACT_GET) ? SL_WAIT : SL_OK, ip_high: hi_r,
                           ip_low: lo_r,
                           mac: (act_r == ACT_GET) ? vword_nxt.mac : mac_r,
                           last: now_r};
              out_r   <= '{status: (act_r == ACT_GET) ? STS_NEW : STS_INSERT,
                           mac_out: '0, slot_out: 8'(vidx_nxt),
                           evicted_valid: vword_nxt.st != SL_UNUSED};
            end else begin
              wen_r <= 1'b0;
            end
          end
        end
        S_RES: state_r <= S_RESW;
        S_RESW: begin
          waddr_r <= addr_r;
          wen_r   <= 1'b1;
          wmed_r  <= 1'b1;
          wword_r <= '{st: SL_OK, ip_high: rdata.ip_high, ip_low: rdata.ip_low,
                       mac: mac_r, last: now_r};
          out_r   <= '{status: STS_DONE, mac_out: '0, slot_out: 8'(addr_r),
                       evicted_valid: 1'b0};
          state_r <= S_DONE;
        end
        S_DONE: begin
          wen_r   <= 1'b0;
          flush_r <= 1'b0;
          addr_r  <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;
  assign out_item  = out_r;

  `ACL_CHK_NXT(a_one_strobe, out_valid, !out_valid)
  `ACL_CHK_NXT(a_take_busy, idle_take, busy)
  `ACL_CHK_IMP(a_evict_claim, out_valid && out_item.evicted_valid,
    out_item.status == STS_NEW || out_item.status == STS_INSERT)
  `ACL_CHK_IMP(a_hit_mac, out_valid && out_item.status != STS_HIT, out_item.mac_out == '0)

endmodule

// ===== tb/arp_cache_lru_checker.sv =====
// checker for the address-resolution cache: predicts and compares result words
`timescale 1ns / 1ps
module arp_cache_lru_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  acl_pkg::acl_in_t  in_item,
  input  logic              out_valid,
  input  acl_pkg::acl_out_t out_item,
  output int                fail_count,
  output int                pending_count,
  output logic              accepted
);
  import acl_pkg::*;

  localparam int NSLOT = ENTRIES_DEF;

  logic [1:0]  cache_st   [NSLOT];
  logic [63:0] cache_hi   [NSLOT];
  logic [63:0] cache_lo   [NSLOT];
  logic [47:0] cache_mac  [NSLOT];
  logic [3:0]  cache_med  [NSLOT];
  logic [31:0] cache_last [NSLOT];

  acl_out_t expected_words[$];
  int mismatches;

  assign pending_count = expected_words.size();
  assign fail_count = mismatches;
  assign accepted = (start && !busy) || out_valid;

  function automatic int find_slot(logic [63:0] hi, logic [63:0] lo, logic [3:0] med);
    for (int i = 0; i < NSLOT; i++)
      if ((cache_st[i] == SL_OK || cache_st[i] == SL_WAIT) && cache_hi[i] == hi &&
          cache_lo[i] == lo && cache_med[i] == med)
        return i;
    return -1;
  endfunction

  function automatic int oldest_slot();
    int v;
    v = 0;
    for (int i = 1; i < NSLOT; i++)
      if (cache_last[i] < cache_last[v]) v = i;
    return v;
  endfunction

  function automatic acl_out_t predict_word(acl_in_t w);
    acl_out_t r;
    logic [63:0] hi, lo;
    int s;
    r = '0;
    r.status = STS_IGNORED;
    hi = w.ip_high;
    lo = w.ip_low;
    if (w.is_v4) begin
      hi = '0;
      lo = V4_PREFIX | {32'd0, w.ip_low[31:0]};
    end
    case (w.action)
      ACT_GET, ACT_ENTER: begin
        if (w.action == ACT_ENTER && w.mac_length != GOOD_MAC_LEN) return r;
        s = find_slot(hi, lo, w.medium_req);
        if (s >= 0) begin
          cache_last[s] = w.now_ms;
          if (w.action == ACT_ENTER) begin
            cache_st[s] = SL_OK;
            cache_mac[s] = w.new_mac;
            r.status = STS_UPDATED;
          end else if (cache_st[s] == SL_WAIT) begin
            r.status = STS_PENDING;
          end else begin
            r.status = STS_HIT;
            r.mac_out = cache_mac[s];
          end
        end else begin
          if (w.action == ACT_ENTER && w.refresh) return r;
          s = oldest_slot();
          r.evicted_valid = cache_st[s] != SL_UNUSED;
          cache_hi[s] = hi;
          cache_lo[s] = lo;
          cache_med[s] = w.medium_req;
          cache_last[s] = w.now_ms;
          if (w.action == ACT_ENTER) begin
            cache_st[s] = SL_OK;
            cache_mac[s] = w.new_mac;
            r.status = STS_INSERT;
          end else begin
            cache_st[s] = SL_WAIT;
            r.status = STS_NEW;
          end
        end
        r.slot_out = s[7:0];
      end
      ACT_RESOLVE: begin
        if (int'(w.entry_index) >= NSLOT) return r;
        s = int'(w.entry_index);
        cache_mac[s] = w.new_mac;
        cache_med[s] = w.medium_req;
        cache_st[s] = SL_OK;
        cache_last[s] = w.now_ms;
        r.status = STS_DONE;
        r.slot_out = w.entry_index;
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          cache_st[i] = SL_UNUSED;
          cache_hi[i] = '0;
          cache_lo[i] = '0;
          cache_mac[i] = '0;
          cache_last[i] = '0;
        end
        r.status = STS_DONE;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    acl_out_t e;
    if (!rst_n) begin
      expected_words.delete();
      mismatches <= 0;
      for (int i = 0; i < NSLOT; i++) begin
        cache_st[i] = SL_UNUSED;
        cache_hi[i] = '0;
        cache_lo[i] = '0;
        cache_mac[i] = '0;
        cache_med[i] = '0;
        cache_last[i] = '0;
      end
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          if (mismatches < 10) $display("unexpected result word %p", out_item);
          mismatches <= mismatches + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.status !== out_item.status || e.mac_out !== out_item.mac_out ||
              e.slot_out !== out_item.slot_out ||
              e.evicted_valid !== out_item.evicted_valid) begin
            if (mismatches < 10)
              $display("mismatch: expected %p actual %p", e, out_item);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy) expected_words.push_back(predict_word(in_item));
    end
  end
endmodule

// ===== tb/arp_cache_lru_tb.sv =====
// testbench top for the address-resolution cache: stimulus and verdict
`timescale 1ns / 1ps
module arp_cache_lru_tb;
  import acl_pkg::*;

  logic clk, rst_n, start, busy, out_valid, accepted;
  acl_in_t in_item;
  acl_out_t out_item;
  int fail_count, pending_count, idle_cycles, gap_pct;
  logic [63:0] ip_pool_hi[8], ip_pool_lo[8];

  arp_cache_lru u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item)
  );

  arp_cache_lru_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count),
    .pending_count(pending_count), .accepted(accepted)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (accepted || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(acl_in_t w);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic acl_in_t random_word();
    acl_in_t w;
    int k;
    w = $bits(acl_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom});
    k = $urandom_range(7);
    if ($urandom_range(99) < 80) begin
      w.ip_high = ip_pool_hi[k];
      w.ip_low = ip_pool_lo[k];
      w.medium_req = 4'($urandom_range(1));
      w.mac_length = ($urandom_range(9) == 0) ? 4'($urandom) : GOOD_MAC_LEN;
      w.now_ms = $urandom_range(63);
    end
    case ($urandom_range(99))
      0: w.action = ACT_FLUSH;
      1, 2, 3, 4, 5, 6, 7, 8, 9, 10: w.action = ACT_RESOLVE;
      default: w.action = ($urandom_range(1) == 1) ? ACT_ENTER : ACT_GET;
    endcase
    return w;
  endfunction

  initial begin
    acl_in_t w;
    rst_n = 0;
    start = 0;
    in_item = '0;
    gap_pct = 6;
    for (int i = 0; i < 8; i++) begin
      ip_pool_hi[i] = {$urandom, $urandom};
      ip_pool_lo[i] = {$urandom, $urandom};
    end
    ip_pool_hi[0] = '1;
    ip_pool_lo[0] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed words
    w = '0;
    w.action = ACT_GET; send_word(w);
    send_word(w);
    w.mac_length = GOOD_MAC_LEN; w.new_mac = '1;
    w.action = ACT_ENTER; send_word(w);
    w.action = ACT_GET; send_word(w);
    w.is_v4 = 1; w.ip_low = '1; w.ip_high = '1; w.medium_req = '1; w.now_ms = '1;
    w.action = ACT_GET; send_word(w);
    w.is_v4 = 0; w.ip_high = 64'd0; w.ip_low = V4_PREFIX | 64'hffff_ffff;
    w.action = ACT_ENTER; send_word(w);
    w.action = ACT_GET; send_word(w);
    w.mac_length = 4'd5; w.action = ACT_ENTER; send_word(w);
    w.mac_length = 4'hf; send_word(w);
    w.mac_length = GOOD_MAC_LEN; w.refresh = 1; w.ip_low = 64'h1234; send_word(w);
    w.refresh = 0; w.now_ms = 32'd0; send_word(w);
    w.action = ACT_RESOLVE; w.entry_index = 8'd255; w.mac_length = 4'd0;
    w.new_mac = 48'h0; send_word(w);
    w.entry_index = 8'd0; w.new_mac = '1; send_word(w);
    w.action = ACT_GET; w.ip_high = 64'd0; w.ip_low = 64'd0; w.medium_req = 4'd0;
    send_word(w);
    w.action = ACT_FLUSH; send_word(w);
    w.action = ACT_GET; send_word(w);
    for (int p = 0; p < 3; p++) begin
      gap_pct = (p == 0) ? 6 : (p == 1) ? 83 : 0;
      for (int n = 0; n < 660; n++) send_word(random_word());
    end
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
